@@ design/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 CBC package
// Shared types, register indexes and round functions of the cipher unit.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int BLK_W    = 128;
    localparam int WORD_W   = 64;
    localparam int NR       = 14;
    localparam int RK_NUM   = NR + 1;
    localparam int RND_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT    = 3'd6;

    localparam logic [RND_W-1:0] RND_FIRST = 4'd0;
    localparam logic [RND_W-1:0] RND_LAST  = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // inverse of the affine output stage of the S-box
    function automatic logic [7:0] aff_inv(input logic [7:0] b);
        return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        return aff_inv(SBOX[aff_inv(y)]);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte b of the state sits at bits 127-8b down
    function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) & 3)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sbox(s[127 - 8*(r + 4*c) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_fwd(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            t[127 - 32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[111 - 32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[103 - 32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    function automatic logic [7:0] m9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic logic [7:0] m11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic logic [7:0] m13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic logic [7:0] m14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [127:0] mix_inv(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            t[127 - 32*c -: 8] = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
            t[119 - 32*c -: 8] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
            t[111 - 32*c -: 8] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
            t[103 - 32*c -: 8] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
        end
        return t;
    endfunction

endpackage

@@ design/aes256_cbc_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// AES-256 CBC cipher unit
// Encrypts or decrypts one 128-bit block per beat, chaining blocks in CBC mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the s_ group: s_tdata carries the block, s_tlast
//   closes a message so that the next block chains from the IV again.
//   Result beats leave on the m_ group, one per input beat, in order.
//   The cfg_ channel writes the key words, IV halves and mode; write it only
//   while no block is in flight. A key write starts a new key expansion,
//   during which s_tready stays low.
//   After the accepting edge the rounds run on the shared round unit, and
//   the result then moves into the output register. The sequencer returns
//   to idle before it takes the next beat, so a new block is taken only
//   once the last one has left the state register. The single round unit
//   works on one block at a time.
//   A finished block is held in the output register while the receiver
//   stalls; the next block may be accepted meanwhile, but its own result
//   waits in the state register until the output register is free.
//   Reset clears the key to zero, starts expansion of the zero key and
//   arms the chain to start from the IV.
// ----------------------------------------------------------------------------
module aes256_cbc_cipher_unit
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BLK_W-1:0]     s_tdata,    // block_high [63:0], block_low [127:64]
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BLK_W-1:0]     m_tdata,    // out_high [63:0], out_low [127:64]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    aes_state_t       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [BLK_W-1:0] s_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [BLK_W-1:0] chain_reg;
    logic             start_iv_reg;
    logic             dec_reg;
    logic             dec_cfg_reg;
    logic [WORD_W-1:0] iv_hi_reg, iv_lo_reg;
    logic             m_valid_reg;
    logic [BLK_W-1:0] m_data_reg;

    logic             cfg_we;
    logic             key_we;
    logic             ks_busy;
    logic [RND_W-1:0] rk_idx;
    logic [BLK_W-1:0] rk;
    logic             in_acc;
    logic             out_free;
    logic [BLK_W-1:0] in_blk;
    logic [BLK_W-1:0] chain_in;
    logic [BLK_W-1:0] round_out;
    logic [BLK_W-1:0] t_fwd, t_inv;
    logic             last_rnd;

    // reorder the beat into cipher byte order: byte 0 at the top
    assign in_blk   = {s_tdata[63:0], s_tdata[127:64]};
    assign cfg_we   = cfg_valid && cfg_ready;
    assign key_we   = cfg_we && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1
                   || cfg_index == REG_KEY_WORD_2 || cfg_index == REG_KEY_WORD_3);
    assign cfg_ready = 1'b1;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign chain_in = start_iv_reg ? {iv_hi_reg, iv_lo_reg} : chain_reg;

    aes_key_sched u_key_sched (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_we   (key_we),
        .key_sel  (cfg_index[1:0]),
        .key_data (cfg_data),
        .rd_idx   (rk_idx),
        .rd_key   (rk),
        .busy     (ks_busy)
    );

    // round key address: whitening key on acceptance, then the round count
    always_comb
    begin
        if (state_reg == ST_IDLE) begin
            rk_idx = dec_cfg_reg ? RND_LAST : RND_FIRST;
        end else begin
            rk_idx = rnd_reg;
        end
    end

    // shared round unit: one full round per cycle
    always_comb
    begin
        last_rnd = dec_reg ? (rnd_reg == RND_FIRST) : (rnd_reg == RND_LAST);
        t_fwd    = sub_shift_fwd(s_reg);
        t_inv    = sub_shift_inv(s_reg) ^ rk;
        if (dec_reg) begin
            round_out = last_rnd ? t_inv : mix_inv(t_inv);
        end else begin
            round_out = (last_rnd ? t_fwd : mix_fwd(t_fwd)) ^ rk;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !ks_busy;
                if (s_tvalid && !ks_busy) begin
                    state_next = ST_ROUND;
                    rnd_next   = dec_cfg_reg ? (RND_LAST - 4'd1) : (RND_FIRST + 4'd1);
                end
            end
            ST_ROUND:
            begin
                if (last_rnd) begin
                    state_next = ST_DONE;
                end else begin
                    rnd_next = dec_reg ? (rnd_reg - 4'd1) : (rnd_reg + 4'd1);
                end
            end
            ST_DONE:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= RND_FIRST;
            start_iv_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
            dec_cfg_reg  <= 1'b0;
            iv_hi_reg    <= '0;
            iv_lo_reg    <= '0;
            chain_reg    <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IV_HIGH: iv_hi_reg   <= cfg_data;
                    REG_IV_LOW:  iv_lo_reg   <= cfg_data;
                    REG_DECRYPT: dec_cfg_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
            // latch the chain on acceptance; rearm from the IV after a last beat
            if (in_acc) begin
                chain_reg    <= chain_in;
                start_iv_reg <= s_tlast;
            end else if (state_reg == ST_DONE && out_free) begin
                chain_reg <= dec_reg ? blk_reg : s_reg;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            blk_reg <= in_blk;
            dec_reg <= dec_cfg_reg;
            s_reg   <= dec_cfg_reg ? (in_blk ^ rk) : (in_blk ^ chain_in ^ rk);
        end else if (state_reg == ST_ROUND) begin
            s_reg <= round_out;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= dec_reg ? (s_reg ^ chain_reg) : s_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg[63:0], m_data_reg[127:64]};

    a_no_accept_in_expansion: assert property (@(posedge clk) disable iff (!rst_n)
        ks_busy |-> !s_tready)
        else $error("input beat accepted during key expansion");

    a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_ROUND)
        else $error("accepted beat did not start rounds");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> rnd_reg <= RND_LAST)
        else $error("round counter out of range");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> $stable(m_data_reg))
        else $error("held result overwritten");

endmodule

@@ design/aes_key_sched.sv @@
// ----------------------------------------------------------------------------
// AES-256 key schedule
// Holds the key words and expands them into fifteen round keys, one per cycle.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               key_we,
    input  logic [1:0]         key_sel,
    input  logic [WORD_W-1:0]  key_data,
    input  logic [RND_W-1:0]   rd_idx,
    output logic [BLK_W-1:0]   rd_key,
    output logic               busy
);

    logic [WORD_W-1:0] key_reg [4];
    logic [BLK_W-1:0]  rk_reg [RK_NUM];
    logic [BLK_W-1:0]  prev2_reg, prev1_reg;
    logic [7:0]        rcon_reg;
    logic [RND_W-1:0]  n_reg;
    logic              busy_reg;

    logic [31:0]       t_word;
    logic [31:0]       w0, w1, w2, w3;
    logic [BLK_W-1:0]  rk_next;

    always_comb
    begin
        if (!n_reg[0]) begin
            t_word = sub_word({prev1_reg[23:0], prev1_reg[31:24]}) ^ {rcon_reg, 24'h0};
        end else begin
            t_word = sub_word(prev1_reg[31:0]);
        end
        w0 = prev2_reg[127:96] ^ t_word;
        w1 = prev2_reg[95:64] ^ w0;
        w2 = prev2_reg[63:32] ^ w1;
        w3 = prev2_reg[31:0] ^ w2;
        rk_next = {w0, w1, w2, w3};
    end

    // control: reset and every key write restart the expansion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b1;
            n_reg    <= RND_FIRST;
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end else if (key_we) begin
            key_reg[key_sel] <= key_data;
            busy_reg         <= 1'b1;
            n_reg            <= RND_FIRST;
        end else if (busy_reg) begin
            if (n_reg == RND_FIRST) begin
                n_reg <= 4'd2;
            end else begin
                n_reg <= n_reg + 4'd1;
                if (n_reg == RND_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !key_we) begin
            if (n_reg == RND_FIRST) begin
                rk_reg[0] <= {key_reg[0], key_reg[1]};
                rk_reg[1] <= {key_reg[2], key_reg[3]};
                prev2_reg <= {key_reg[0], key_reg[1]};
                prev1_reg <= {key_reg[2], key_reg[3]};
                rcon_reg  <= 8'h01;
            end else begin
                rk_reg[n_reg] <= rk_next;
                prev2_reg     <= prev1_reg;
                prev1_reg     <= rk_next;
                if (!n_reg[0]) begin
                    rcon_reg <= xt(rcon_reg);
                end
            end
        end
    end

    assign rd_key = rk_reg[rd_idx];
    assign busy   = busy_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 CBC cipher unit testbench
// Drives blocks, register writes and output stalls into the cipher unit and
// checks every result block against an in-house CBC model of AES-256.
// ----------------------------------------------------------------------------

// Tracks the expected CBC chain and holds the result blocks still owed.
class cbc_scoreboard;
    typedef logic [7:0] blk_t [16];

    logic [7:0]  fwd_tab [256];
    logic [7:0]  inv_tab [256];
    logic [63:0] key_reg [4];
    logic [63:0] iv_hi, iv_lo;
    logic        decrypting;
    logic [63:0] chain_hi, chain_lo;
    logic        chain_restart;
    logic [63:0] rkey [30];
    logic [127:0] owed [$];
    int          mismatches;

    function new();
        logic [7:0] sq, r;
        logic [7:0] b;
        for (int x = 0; x < 256; x++)
        begin
            sq = 8'(x);
            r = 8'd1;
            for (int k = 1; k < 8; k++)
            begin
                sq = gmul(sq, sq);
                r = gmul(r, sq);
            end
            b = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
                ^ {r[3:0], r[7:4]} ^ 8'h63;
            fwd_tab[x] = b;
            inv_tab[b] = 8'(x);
        end
        foreach (key_reg[i]) key_reg[i] = '0;
        iv_hi = '0;
        iv_lo = '0;
        decrypting = 1'b0;
        chain_hi = '0;
        chain_lo = '0;
        chain_restart = 1'b1;
        mismatches = 0;
        expand();
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] p;
        x = {1'b0, a};
        p = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k]) p ^= x[7:0];
            x = x << 1;
            if (x[8]) x ^= 9'h11b;
        end
        return p;
    endfunction

    function logic [31:0] sub32(logic [31:0] w);
        return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
    endfunction

    function void expand();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'd1;
        for (int i = 0; i < 8; i++)
            w[i] = (i & 1) ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = sub32({t[23:0], t[31:24]}) ^ {rcon, 24'd0};
                rcon = gmul(rcon, 8'd2);
            end
            else if (i % 8 == 4)
                t = sub32(t);
            w[i] = w[i-8] ^ t;
        end
        for (int i = 0; i < 30; i++) rkey[i] = {w[2*i], w[2*i+1]};
    endfunction

    function blk_t unpack(logic [63:0] hi, logic [63:0] lo);
        blk_t s;
        for (int i = 0; i < 8; i++)
        begin
            s[i]   = hi[63 - 8*i -: 8];
            s[8+i] = lo[63 - 8*i -: 8];
        end
        return s;
    endfunction

    function blk_t add_round(blk_t s, int rnd);
        blk_t k;
        k = unpack(rkey[2*rnd], rkey[2*rnd+1]);
        for (int i = 0; i < 16; i++) s[i] ^= k[i];
        return s;
    endfunction

    function blk_t subst_rows(blk_t s, bit inverse);
        blk_t t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inverse) t[r + 4*((c + r) & 3)] = inv_tab[s[r + 4*c]];
                else         t[r + 4*c] = fwd_tab[s[r + 4*((c + r) & 3)]];
        return t;
    endfunction

    function blk_t mix_cols(blk_t s, bit inverse);
        logic [7:0] fm [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
        logic [7:0] im [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
        logic [7:0] a [4];
        logic [7:0] b;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++) a[r] = s[r + 4*c];
            for (int r = 0; r < 4; r++)
            begin
                b = '0;
                for (int k = 0; k < 4; k++)
                    b ^= gmul(inverse ? im[(k-r+4) & 3] : fm[(k-r+4) & 3], a[k]);
                s[r + 4*c] = b;
            end
        end
        return s;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
        case (idx)
            aes_pkg::REG_KEY_WORD_0, aes_pkg::REG_KEY_WORD_1,
            aes_pkg::REG_KEY_WORD_2, aes_pkg::REG_KEY_WORD_3:
            begin
                key_reg[idx[1:0]] = data;
                expand();
            end
            aes_pkg::REG_IV_HIGH: iv_hi = data;
            aes_pkg::REG_IV_LOW:  iv_lo = data;
            aes_pkg::REG_DECRYPT: decrypting = data[0];
            default: ;
        endcase
    endfunction

    // Work out the result of one accepted block and advance the chain.
    function void note_block(logic [63:0] hi, logic [63:0] lo, logic last);
        blk_t s, c;
        logic [63:0] rh, rl;
        if (chain_restart)
        begin
            chain_hi = iv_hi;
            chain_lo = iv_lo;
            chain_restart = 1'b0;
        end
        s = unpack(hi, lo);
        c = unpack(chain_hi, chain_lo);
        if (decrypting)
        begin
            s = add_round(s, 14);
            for (int r = 13; r > 0; r--)
            begin
                s = subst_rows(s, 1'b1);
                s = add_round(s, r);
                s = mix_cols(s, 1'b1);
            end
            s = subst_rows(s, 1'b1);
            s = add_round(s, 0);
            for (int i = 0; i < 16; i++) s[i] ^= c[i];
        end
        else
        begin
            for (int i = 0; i < 16; i++) s[i] ^= c[i];
            s = add_round(s, 0);
            for (int r = 1; r < 14; r++)
            begin
                s = subst_rows(s, 1'b0);
                s = mix_cols(s, 1'b0);
                s = add_round(s, r);
            end
            s = subst_rows(s, 1'b0);
            s = add_round(s, 14);
        end
        for (int i = 0; i < 8; i++)
        begin
            rh[63 - 8*i -: 8] = s[i];
            rl[63 - 8*i -: 8] = s[8+i];
        end
        if (decrypting)
        begin
            chain_hi = hi;
            chain_lo = lo;
        end
        else
        begin
            chain_hi = rh;
            chain_lo = rl;
        end
        if (last) chain_restart = 1'b1;
        owed.push_back({rl, rh});
    endfunction

    function void check_block(logic [127:0] got);
        logic [127:0] want;
        if (owed.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: hi %h lo %h", got[63:0], got[127:64]);
            return;
        end
        want = owed.pop_front();
        if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected hi %h lo %h, got hi %h lo %h",
                         want[63:0], want[127:64], got[63:0], got[127:64]);
        end
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module testbench;
    import aes_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BLK_W-1:0]     s_tdata;    // block_high [63:0], block_low [127:64]
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BLK_W-1:0]     m_tdata;    // out_high [63:0], out_low [127:64]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    cbc_scoreboard sb = new();
    int  stall_style;
    int  stall_left;
    int  sent;

    aes256_cbc_cipher_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Hard stop, far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: switch between no stalls, light stalls and long stalls.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(50, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check every result beat as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_block(m_tdata);
    end

    // Present one block and hold it until taken; drop valid after a burst.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic last, input int gap);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_block(hi, lo, last);
        sent++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every owed result has come, then let the core settle.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Burst sender: short gaps inside a burst are zero, a gap closes a burst.
    function automatic int next_gap();
        if ($urandom_range(0, 5) != 0) return 0;
        return $urandom_range(1, 20);
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_block(rand_word(), rand_word(), i == len - 1, next_gap());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_WORD_0;
        cfg_data = '0;
        stall_style = 0;
        stall_left = 0;
        sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero key straight out of reset, field extremes, chained message.
        send_block('0, '0, 1'b0, 0);
        send_block('1, '1, 1'b1, 3);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 0);
        send_block('1, '0, 1'b0, 0);
        send_block('0, '1, 1'b1, 0);
        drain();

        // Full-ones key and IV.
        write_reg(REG_KEY_WORD_0, '1);
        write_reg(REG_KEY_WORD_1, '1);
        write_reg(REG_KEY_WORD_2, '1);
        write_reg(REG_KEY_WORD_3, '1);
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, '1);
        send_block('0, '0, 1'b0, 0);
        send_block('1, '1, 1'b0, 0);
        drain();
        // IV changed mid-message only applies from the next message.
        write_reg(REG_IV_HIGH, 64'h0011223344556677);
        send_block('1, '0, 1'b1, 0);
        send_block('0, '1, 1'b0, 0);
        drain();
        // Mode changed mid-message keeps the chain.
        write_reg(REG_DECRYPT, 64'd1);
        send_block('0, '0, 1'b0, 0);
        send_block('1, '1, 1'b1, 0);
        send_block(64'h8000000000000001, 64'h7ffffffffffffffe, 1'b0, 0);
        drain();
        // Out-of-range register index does nothing.
        write_reg(3'd7, '1);
        write_reg(REG_DECRYPT, 64'd0);
        send_block(64'h8000000000000001, 64'h7ffffffffffffffe, 1'b1, 0);
        send_block('0, '0, 1'b1, 0);
        drain();

        // Random phases: fresh settings, then messages and loose single blocks.
        while (sent < 1900)
        begin
            drain();
            repeat ($urandom_range(1, 5))
                write_reg(CFG_IDX_W'($urandom_range(0, 7)), rand_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_DECRYPT, 64'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 10))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_block(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                               next_gap());
                else
                    send_message($urandom_range(1, 6));
            end
            // Occasionally leave a message open across the settings change.
            if ($urandom_range(0, 2) == 0)
                send_block(rand_word(), rand_word(), 1'b0, next_gap());
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

@@ sim.f @@
design/aes_pkg.sv
design/aes_key_sched.sv
design/aes256_cbc_cipher_unit.sv
tb/testbench.sv
